[rtl/pidff_pkg.sv]
// ----------------------------------------------------------------------------
// pidff_pkg
// shared types, register indexes, constants and saturation helper for the
// pid controller with feedforward and bang-bang mode
// ----------------------------------------------------------------------------
package pidff_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET      = 3'd0;
    localparam logic [2:0] CFG_GAIN_P      = 3'd1;
    localparam logic [2:0] CFG_GAIN_I      = 3'd2;
    localparam logic [2:0] CFG_GAIN_D      = 3'd3;
    localparam logic [2:0] CFG_TICK_PERIOD = 3'd4;
    localparam logic [2:0] CFG_TICK_RATE   = 3'd5;
    localparam logic [2:0] CFG_INT_BOUND   = 3'd6;
    localparam logic [2:0] CFG_DRIVE_CEIL  = 3'd7;

    // mode codes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_FF    = 2'd1;
    localparam logic [1:0] MODE_BANG  = 2'd2;

    // q16.16 constants
    localparam logic signed [31:0] HALF_Q     = 32'sd32768;
    localparam logic signed [31:0] NEG_HALF_Q = -32'sd32768;
    localparam logic [30:0]        ONE_Q      = 31'd65536;
    localparam logic [30:0]        RST_TICK   = 31'd65536;

    // width of a multiplier product after the q16 floor shift
    localparam int unsigned PROD_W = 50;

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ERR  = 9'b000000010,
        S_MP   = 9'b000000100,
        S_MI   = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_MIG  = 9'b000100000,
        S_MD1  = 9'b001000000,
        S_MD   = 9'b010000000,
        S_SUM  = 9'b100000000
    } t_state;

    // saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input t_prod v);
        t_prod hi;
        t_prod lo;
        hi = t_prod'(64'sd2147483647);
        lo = t_prod'(-64'sd2147483648);
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[rtl/pidff_mul.sv]
// ----------------------------------------------------------------------------
// pidff_mul
// shared signed 33x33 multiplier with q16 floor shift
// ----------------------------------------------------------------------------
module pidff_mul (
    input  logic signed [32:0]  i_a,
    input  logic signed [32:0]  i_b,
    output pidff_pkg::t_prod    o_prod_q
);
    import pidff_pkg::*;

    logic signed [65:0] w_full;

    assign w_full   = i_a * i_b;
    // arithmetic shift right of a two's complement value rounds toward -inf
    assign o_prod_q = w_full[65:16];

endmodule

[rtl/pid_ff_bangbang_controller_top.sv]
// ----------------------------------------------------------------------------
// pid_ff_bangbang_controller_top
// one control tick per input transfer: pid drive with optional feedforward
// and a bang-bang override; inputs signed q16.16, drive unsigned q15.16
// order: a bang-bang answer is written to the result register from the error
//   step, a pid answer from the sum step after one multiplier pass per
//   product, five products in sequence, plus error, accumulate and sum steps;
//   a new input is taken only back in idle, after the last answer has gone into
//   the result register; both answers wait while the result register is still full
// reset: synchronous active low; sets config registers and state to reset values,
//   integral and previous error to zero, and empties the result register
// ----------------------------------------------------------------------------
module pid_ff_bangbang_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_measured,
    input  logic signed [31:0] i_feedforward,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [30:0]        o_drive
);
    import pidff_pkg::*;

    // configuration registers
    logic signed [31:0] r_target, r_gain_p, r_gain_i, r_gain_d;
    logic [30:0]        r_tick_period, r_tick_rate, r_bound, r_ceiling;

    // controller state carried between ticks
    logic signed [31:0] r_integ, r_prev_err;

    // item latched at the input transfer
    logic [1:0]         r_mode;
    logic signed [31:0] r_meas, r_ff;

    // working registers
    t_state             r_state, n_state;
    logic signed [31:0] r_err, r_diff;
    t_prod              r_prod;
    logic signed [33:0] r_sum;

    // result register
    logic               r_out_valid;
    logic [30:0]        r_drive;

    // combinational signals
    logic signed [32:0] w_err_full, w_diff_full;
    logic signed [31:0] w_err, w_diff;
    logic               w_bang;
    logic [30:0]        w_bang_drive;
    logic               w_out_free;
    logic signed [32:0] w_mul_a, w_mul_b;
    t_prod              w_mul_q;
    logic signed [31:0] w_prod_sat;
    logic signed [50:0] w_acc, w_bound51;
    logic signed [31:0] w_acc_clamped;
    logic signed [33:0] w_sum;
    logic [30:0]        w_pid_drive;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    // the result register can take a new value when empty or being drained
    assign w_out_free = !r_out_valid || i_ready;

    // error and its difference from the last tick, both saturated
    assign w_err_full  = {r_target[31], r_target} - {r_meas[31], r_meas};
    assign w_err       = sat32(t_prod'(w_err_full));
    assign w_diff_full = {w_err[31], w_err} - {r_prev_err[31], r_prev_err};
    assign w_diff      = sat32(t_prod'(w_diff_full));

    // bang-bang override: |e| strictly above one half
    assign w_bang       = (r_mode == MODE_BANG) && ((w_err > HALF_Q) || (w_err < NEG_HALF_Q));
    assign w_bang_drive = (w_err > 32'sd0) ? r_ceiling : ONE_Q;

    assign w_prod_sat = sat32(r_prod);

    // operand select for the shared multiplier, one product per state
    always_comb begin
        w_mul_a = {r_gain_p[31], r_gain_p};
        w_mul_b = {r_err[31], r_err};
        unique case (r_state)
            S_MI: begin
                w_mul_a = {r_err[31], r_err};
                w_mul_b = {2'b00, r_tick_period};
            end
            S_MIG: begin
                w_mul_a = {r_gain_i[31], r_gain_i};
                w_mul_b = {r_integ[31], r_integ};
            end
            S_MD1: begin
                w_mul_a = {r_gain_d[31], r_gain_d};
                w_mul_b = {r_diff[31], r_diff};
            end
            S_MD: begin
                // derivative scaled by the configured 1/dt
                w_mul_a = {w_prod_sat[31], w_prod_sat};
                w_mul_b = {2'b00, r_tick_rate};
            end
            default: begin
                w_mul_a = {r_gain_p[31], r_gain_p};
                w_mul_b = {r_err[31], r_err};
            end
        endcase
    end

    pidff_mul u_mul (
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_prod_q (w_mul_q)
    );

    // integral accumulate and clamp to +-bound
    assign w_acc     = 51'(r_integ) + 51'(r_prod);
    assign w_bound51 = $signed({20'd0, r_bound});
    always_comb begin
        if (w_acc > w_bound51) begin
            w_acc_clamped = $signed({1'b0, r_bound});
        end else if (w_acc < -w_bound51) begin
            w_acc_clamped = -$signed({1'b0, r_bound});
        end else begin
            w_acc_clamped = w_acc[31:0];
        end
    end

    // final sum: p + i already in r_sum, add d and feedforward in mode 1
    assign w_sum = r_sum + 34'(w_prod_sat) + ((r_mode == MODE_FF) ? 34'(r_ff) : 34'sd0);
    always_comb begin
        if (w_sum < 34'sd0) begin
            w_pid_drive = '0;
        end else if (w_sum > $signed({3'd0, r_ceiling})) begin
            w_pid_drive = r_ceiling;
        end else begin
            w_pid_drive = w_sum[30:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_ERR;
            S_ERR: begin
                if (!w_bang) begin
                    n_state = S_MP;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MP:  n_state = S_MI;
            S_MI:  n_state = S_ACC;
            S_ACC: n_state = S_MIG;
            S_MIG: n_state = S_MD1;
            S_MD1: n_state = S_MD;
            S_MD:  n_state = S_SUM;
            S_SUM: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= '0;
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_tick_period <= RST_TICK;
            r_tick_rate   <= RST_TICK;
            r_bound       <= '0;
            r_ceiling     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET:      r_target      <= i_cfg_data;
                CFG_GAIN_P:      r_gain_p      <= i_cfg_data;
                CFG_GAIN_I:      r_gain_i      <= i_cfg_data;
                CFG_GAIN_D:      r_gain_d      <= i_cfg_data;
                CFG_TICK_PERIOD: r_tick_period <= i_cfg_data[30:0];
                CFG_TICK_RATE:   r_tick_rate   <= i_cfg_data[30:0];
                CFG_INT_BOUND:   r_bound       <= i_cfg_data[30:0];
                CFG_DRIVE_CEIL:  r_ceiling     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // control state, tick state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_integ <= w_acc_clamped;
            end
            if (r_state == S_MD) begin
                r_prev_err <= r_err;
            end
            if ((r_state == S_ERR) && w_bang && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_SUM) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_mode <= i_mode;
            r_meas <= i_measured;
            r_ff   <= i_feedforward;
        end
        if (r_state == S_ERR) begin
            r_err  <= w_err;
            r_diff <= w_diff;
        end
        if ((r_state == S_MP) || (r_state == S_MI) || (r_state == S_MIG) ||
            (r_state == S_MD1) || (r_state == S_MD)) begin
            r_prod <= w_mul_q;
        end
        if (r_state == S_MI) begin
            r_sum <= 34'(w_prod_sat);
        end else if (r_state == S_MD1) begin
            r_sum <= r_sum + 34'(w_prod_sat);
        end
        if ((r_state == S_ERR) && w_bang && w_out_free) begin
            r_drive <= w_bang_drive;
        end else if ((r_state == S_SUM) && w_out_free) begin
            r_drive <= w_pid_drive;
        end
    end

`ifndef SYNTHESIS
    // an input transfer always starts the error step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_ERR))
        else $error("input transfer did not start the error step");

    // finishing the sum step always leaves a result waiting
    a_sum_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && (n_state == S_IDLE)) |=> o_valid)
        else $error("sum step finished without a result");

    // the accumulate step leaves the integral inside its bound
    a_integ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> ((r_integ <= $signed({1'b0, r_bound})) &&
                                (r_integ >= -$signed({1'b0, r_bound}))))
        else $error("integral outside its bound after accumulate");
`endif

endmodule
